@@ src/fatd_pkg.sv @@
// Package for the fully associative LRU tag directory.
// Holds the sequencer state type and the fixed width of the reported tag.
// No dependencies.
package fatd_pkg;

  localparam int unsigned OUT_TAG_W = 42;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_AGE    = 4'b1000
  } state_t;

endpackage

@@ src/fatd_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the tag and recency store of the tag directory.
// No dependencies.
module fatd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/fully_assoc_lru_tag_directory.sv @@
// Top level of the fully associative LRU tag directory (write-through cache).
// Depends on fatd_pkg and fatd_ram.
//
// Channel   Direction  Handshake          Ports
// input     in         start / busy       in_mode, in_address, in_write_matches
// result    out        out_valid strobe   out_hit, out_fetch_line, out_write_through,
//                                         out_evicted, out_evicted_tag
//
// A word is accepted when start is high and busy is low. A search pass reads every line
// through the single read port of the tag RAM, one line a cycle, with one shared tag
// and rank compare. An access that records a tag adds an aging pass over the same port.
// The result is shown for one cycle after busy falls, and the receiver cannot hold it
// off, so nothing stalls the block.
// Reset clears the valid bits, the occupancy count and the sequencer at once.
module fully_assoc_lru_tag_directory #(
  parameter int unsigned LINES          = 128,
  parameter int unsigned BYTES_PER_LINE = 64,
  parameter int unsigned ADDR_BITS      = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [ADDR_BITS-1:0]           in_address,
  input  logic                           in_write_matches,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic                           out_fetch_line,
  output logic                           out_write_through,
  output logic                           out_evicted,
  output logic [fatd_pkg::OUT_TAG_W-1:0] out_evicted_tag
);

  localparam int unsigned OFF_W   = $clog2(BYTES_PER_LINE);
  localparam int unsigned TAG_W   = ADDR_BITS - OFF_W;
  localparam int unsigned IDX_W   = $clog2(LINES);
  localparam int unsigned RANK_W  = IDX_W;
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned LIMIT_W = RANK_W + 1;
  localparam int unsigned WORD_W  = TAG_W + RANK_W;

  fatd_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic               pend_vld_r;
  logic [IDX_W-1:0]   pend_idx_r;
  logic [LINES-1:0]   valid_r;
  logic [CNT_W-1:0]   occ_r;

  logic [TAG_W-1:0]   tag_r;
  logic               mode_r;
  logic               match_r;
  logic               found_r;
  logic [IDX_W-1:0]   found_idx_r;
  logic [RANK_W-1:0]  found_rank_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [IDX_W-1:0]   victim_idx_r;
  logic [TAG_W-1:0]   victim_tag_r;
  logic [IDX_W-1:0]   target_idx_r;
  logic [LIMIT_W-1:0] limit_r;

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic                           out_fetch_r;
  logic                           out_wt_r;
  logic                           out_evicted_r;
  logic [fatd_pkg::OUT_TAG_W-1:0] out_evicted_tag_r;

  logic               accept;
  logic               issue;
  logic               last;
  logic               pend_valid_bit;
  logic               need_rec;
  logic               full;
  logic               wr_en;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  rd_data;
  logic [TAG_W-1:0]   rd_tag;
  logic [RANK_W-1:0]  rd_rank;

  assign busy           = (state_r != fatd_pkg::ST_IDLE);
  assign accept         = start && (state_r == fatd_pkg::ST_IDLE);
  assign issue          = ((state_r == fatd_pkg::ST_SCAN) || (state_r == fatd_pkg::ST_AGE)) &&
                          (cnt_r < CNT_W'(LINES));
  assign last           = pend_vld_r && (pend_idx_r == IDX_W'(LINES - 1));
  assign pend_valid_bit = valid_r[pend_idx_r];
  assign rd_tag         = rd_data[WORD_W-1:RANK_W];
  assign rd_rank        = rd_data[RANK_W-1:0];
  assign full           = (occ_r == CNT_W'(LINES));
  assign need_rec       = mode_r ? (!found_r || !match_r) : !found_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = {rd_tag, rd_rank + RANK_W'(1)};
    if ((state_r == fatd_pkg::ST_AGE) && pend_vld_r) begin
      if (pend_idx_r == target_idx_r) begin
        wr_en   = 1'b1;
        wr_data = {tag_r, {RANK_W{1'b0}}};
      end else if (pend_valid_bit && ({1'b0, rd_rank} < limit_r)) begin
        wr_en = 1'b1;
      end
    end
  end

  fatd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LINES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pend_idx_r),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fatd_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fatd_pkg::ST_SCAN;
        end
      end
      fatd_pkg::ST_SCAN: begin
        if (last) begin
          state_nxt = fatd_pkg::ST_DECIDE;
        end
      end
      fatd_pkg::ST_DECIDE: begin
        state_nxt = need_rec ? fatd_pkg::ST_AGE : fatd_pkg::ST_IDLE;
      end
      fatd_pkg::ST_AGE: begin
        if (last) begin
          state_nxt = fatd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fatd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fatd_pkg::ST_IDLE;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= issue;
      out_valid_r <= ((state_r == fatd_pkg::ST_DECIDE) && !need_rec) ||
                     ((state_r == fatd_pkg::ST_AGE) && last);
      if (accept) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (state_r == fatd_pkg::ST_DECIDE) begin
        cnt_r <= '0;
      end
      if ((state_r == fatd_pkg::ST_DECIDE) && need_rec && !found_r && !full) begin
        valid_r[free_idx_r] <= 1'b1;
        occ_r               <= occ_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      tag_r        <= in_address[ADDR_BITS-1:OFF_W];
      mode_r       <= in_mode;
      match_r      <= in_write_matches;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end
    if ((state_r == fatd_pkg::ST_SCAN) && pend_vld_r) begin
      if (pend_valid_bit && (rd_tag == tag_r)) begin
        found_r      <= 1'b1;
        found_idx_r  <= pend_idx_r;
        found_rank_r <= rd_rank;
      end
      if (!pend_valid_bit && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= pend_idx_r;
      end
      if (pend_valid_bit && (rd_rank == RANK_W'(LINES - 1))) begin
        victim_idx_r <= pend_idx_r;
        victim_tag_r <= rd_tag;
      end
    end
    if (state_r == fatd_pkg::ST_DECIDE) begin
      out_hit_r     <= found_r;
      out_fetch_r   <= !mode_r && !found_r;
      out_wt_r      <= mode_r && need_rec;
      out_evicted_r <= need_rec && !found_r && full;
      if (need_rec && !found_r && full) begin
        out_evicted_tag_r <= fatd_pkg::OUT_TAG_W'(victim_tag_r);
      end else begin
        out_evicted_tag_r <= '0;
      end
      if (found_r) begin
        target_idx_r <= found_idx_r;
        limit_r      <= {1'b0, found_rank_r};
      end else begin
        target_idx_r <= full ? victim_idx_r : free_idx_r;
        limit_r      <= LIMIT_W'(LINES);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_fetch_line    = out_fetch_r;
  assign out_write_through = out_wt_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_tag   = out_evicted_tag_r;

endmodule

@@ src/fatd_checker.sv @@
// Port-level checker for the fully associative LRU tag directory.
// Depends on fatd_pkg; bound to fully_assoc_lru_tag_directory below.
module fatd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic                           out_hit,
  input logic                           out_fetch_line,
  input logic                           out_write_through,
  input logic                           out_evicted,
  input logic [fatd_pkg::OUT_TAG_W-1:0] out_evicted_tag
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted word did not raise busy.");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while still busy.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_hit_no_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (!out_fetch_line && !out_evicted))
    else $error("Hit reported together with a fetch or an eviction.");

  a_evict_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_tag == '0))
    else $error("Evicted tag is not zero without an eviction.");

endmodule

bind fully_assoc_lru_tag_directory fatd_checker u_fatd_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the fully associative LRU tag directory.
// Drives directed and random accesses and checks every result word against a directed table entry or an LRU predictor.
// Depends on fatd_pkg and fully_assoc_lru_tag_directory.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned OUT_TAG_W      = fatd_pkg::OUT_TAG_W;
  localparam int unsigned LINES          = 128;
  localparam int unsigned BYTES_PER_LINE = 64;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned CLK_PERIOD = 8;
  localparam int unsigned WORDS_TOTAL = 1850;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 2 * LINES + 8;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef struct packed {
    logic                 hit;
    logic                 fetch_line;
    logic                 write_through;
    logic                 evicted;
    logic [OUT_TAG_W-1:0] evicted_tag;
  } result_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic              write_matches;
  } access_t;

  typedef struct packed {
    access_t acc;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t RES_NONE     = '0;
  localparam result_t RES_HIT_ONLY = '{1'b1, 1'b0, 1'b0, 1'b0, '0};
  localparam result_t RES_RD_MISS  = '{1'b0, 1'b1, 1'b0, 1'b0, '0};
  localparam result_t RES_WR_MISS  = '{1'b0, 1'b0, 1'b1, 1'b0, '0};
  localparam result_t RES_WR_HIT   = '{1'b1, 1'b0, 1'b1, 1'b0, '0};

  localparam int unsigned DIR_ROWS = 20;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{MODE_READ,  48'h0000_0000_0000, 1'b0}, 1'b1, RES_RD_MISS},
    '{'{MODE_READ,  48'h0000_0000_003F, 1'b1}, 1'b1, RES_HIT_ONLY},
    '{'{MODE_WRITE, 48'h0000_0000_0000, 1'b1}, 1'b1, RES_HIT_ONLY},
    '{'{MODE_WRITE, 48'h0000_0000_0020, 1'b0}, 1'b1, RES_WR_HIT},
    '{'{MODE_WRITE, 48'hFFFF_FFFF_FFFF, 1'b1}, 1'b1, RES_WR_MISS},
    '{'{MODE_READ,  48'hFFFF_FFFF_FFC0, 1'b0}, 1'b1, RES_HIT_ONLY},
    '{'{MODE_WRITE, 48'h0000_0000_0040, 1'b0}, 1'b1, RES_WR_MISS},
    '{'{MODE_READ,  48'h0000_0000_007F, 1'b0}, 1'b1, RES_HIT_ONLY},
    '{'{MODE_READ,  48'h8000_0000_0000, 1'b0}, 1'b1, RES_RD_MISS},
    '{'{MODE_WRITE, 48'h5555_5555_5555, 1'b1}, 1'b1, RES_WR_MISS},
    '{'{MODE_WRITE, 48'hAAAA_AAAA_AAAA, 1'b0}, 1'b1, RES_WR_MISS},
    '{'{MODE_READ,  48'hAAAA_AAAA_AA80, 1'b0}, 1'b1, RES_HIT_ONLY},
    '{'{MODE_READ,  48'h0000_0000_0080, 1'b0}, 1'b1, RES_RD_MISS},
    '{'{MODE_WRITE, 48'h0000_0000_0000, 1'b0}, 1'b1, RES_WR_HIT},
    '{'{MODE_READ,  48'h5555_5555_5540, 1'b1}, 1'b1, RES_HIT_ONLY},
    '{'{MODE_READ,  48'h1234_5678_9ABC, 1'b0}, 1'b0, RES_NONE},
    '{'{MODE_WRITE, 48'h1234_5678_9AFF, 1'b1}, 1'b0, RES_NONE},
    '{'{MODE_WRITE, 48'hFFFF_FFFF_FFC0, 1'b0}, 1'b0, RES_NONE},
    '{'{MODE_READ,  48'h0000_0000_0040, 1'b0}, 1'b0, RES_NONE},
    '{'{MODE_WRITE, 48'h8000_0000_003F, 1'b1}, 1'b0, RES_NONE}
  };

  localparam int unsigned POOL_SIZES [8] = '{4, 32, 120, 128, 129, 136, 160, 256};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_mode = 1'b0;
  logic [ADDR_W-1:0] in_address = '0;
  logic              in_write_matches = 1'b0;
  logic              out_valid;
  logic              out_hit;
  logic              out_fetch_line;
  logic              out_write_through;
  logic              out_evicted;
  logic [OUT_TAG_W-1:0] out_evicted_tag;

  logic [OUT_TAG_W-1:0] dir_tag [LINES];
  bit                   dir_valid [LINES];
  int unsigned          dir_rank [LINES];

  logic [OUT_TAG_W-1:0] tag_pool [256];
  result_t              pending_results [$];
  int unsigned          words_sent = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          stall_cycles = 0;
  result_t              got_word;
  result_t              want_word;

  fully_assoc_lru_tag_directory #(
    .LINES          (LINES),
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .ADDR_BITS      (ADDR_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_address       (in_address),
    .in_write_matches (in_write_matches),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_fetch_line   (out_fetch_line),
    .out_write_through(out_write_through),
    .out_evicted      (out_evicted),
    .out_evicted_tag  (out_evicted_tag)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void age_younger(int unsigned limit);
    for (int i = 0; i < LINES; i++) begin
      if (dir_valid[i] && dir_rank[i] < limit) begin
        dir_rank[i]++;
      end
    end
  endfunction

  function automatic void record_line(logic [OUT_TAG_W-1:0] tag, int found, inout result_t r);
    int slot;
    if (found >= 0) begin
      age_younger(dir_rank[found]);
      dir_rank[found] = 0;
      return;
    end
    slot = -1;
    for (int i = 0; i < LINES; i++) begin
      if (!dir_valid[i] && slot < 0) begin
        slot = i;
      end
    end
    if (slot >= 0) begin
      age_younger(LINES);
      dir_valid[slot] = 1'b1;
      dir_tag[slot] = tag;
      dir_rank[slot] = 0;
      return;
    end
    slot = 0;
    for (int i = 1; i < LINES; i++) begin
      if (dir_rank[i] > dir_rank[slot]) begin
        slot = i;
      end
    end
    r.evicted = 1'b1;
    r.evicted_tag = dir_tag[slot];
    age_younger(dir_rank[slot]);
    dir_tag[slot] = tag;
    dir_rank[slot] = 0;
  endfunction

  function automatic result_t directory_access(access_t a);
    result_t r;
    logic [OUT_TAG_W-1:0] tag;
    int found;
    r = '0;
    tag = OUT_TAG_W'(a.address / BYTES_PER_LINE);
    found = -1;
    for (int i = 0; i < LINES; i++) begin
      if (found < 0 && dir_valid[i] && dir_tag[i] == tag) begin
        found = i;
      end
    end
    r.hit = (found >= 0);
    if (a.mode == MODE_READ) begin
      if (found < 0) begin
        r.fetch_line = 1'b1;
        record_line(tag, found, r);
      end
    end else if (found < 0 || !a.write_matches) begin
      r.write_through = 1'b1;
      record_line(tag, found, r);
    end
    return r;
  endfunction

  function automatic access_t random_access(int unsigned pool_n);
    access_t a;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    a.mode = 1'($urandom_range(1));
    a.write_matches = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      a.address = {tag_pool[8'($urandom_range(pool_n - 1))], r[5:0]};
    end else begin
      a.address = r[ADDR_W-1:0];
    end
    return a;
  endfunction

  task automatic load_pool(int unsigned pool_n);
    logic [63:0] base;
    logic [63:0] r;
    base = {$urandom(), $urandom()};
    for (int i = 0; i < pool_n; i++) begin
      r = {$urandom(), $urandom()};
      if (r[63]) begin
        tag_pool[i] = base[OUT_TAG_W-1:0] ^ (OUT_TAG_W'(1) << $urandom_range(OUT_TAG_W - 1));
      end else begin
        tag_pool[i] = r[OUT_TAG_W-1:0];
      end
    end
  endtask

  task automatic send_word(access_t a, logic typed, result_t want);
    result_t predicted;
    start <= 1'b1;
    in_mode <= a.mode;
    in_address <= a.address;
    in_write_matches <= a.write_matches;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predicted = directory_access(a);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    words_sent++;
  endtask

  task automatic idle_gap(int unsigned cycles);
    logic [63:0] r;
    repeat (cycles) begin
      r = {$urandom(), $urandom()};
      start <= 1'b0;
      in_mode <= r[63];
      in_address <= r[ADDR_W-1:0];
      in_write_matches <= r[62];
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_word = '{out_hit, out_fetch_line, out_write_through, out_evicted, out_evicted_tag};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result word with nothing expected, got %0h", $time, got_word);
        end
      end else begin
        want_word = pending_results[0];
        pending_results.delete(0);
        check_field("hit", 64'(want_word.hit), 64'(got_word.hit));
        check_field("fetch_line", 64'(want_word.fetch_line), 64'(got_word.fetch_line));
        check_field("write_through", 64'(want_word.write_through),
                    64'(got_word.write_through));
        check_field("evicted", 64'(want_word.evicted), 64'(got_word.evicted));
        check_field("evicted_tag", 64'(want_word.evicted_tag), 64'(got_word.evicted_tag));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned pool_n;
    int unsigned phase;
    int unsigned phase_end;
    int unsigned burst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(DIR_TABLE[i].acc, DIR_TABLE[i].typed, DIR_TABLE[i].want);
      if (i % 4 == 3) begin
        idle_gap($urandom_range(1, 200));
      end
    end
    drain_results();

    // The first phase uses a working set larger than the directory so that it fills up.
    phase = 0;
    while (words_sent < WORDS_TOTAL) begin
      pool_n = (phase == 0) ? 200 : POOL_SIZES[3'($urandom_range(7))];
      load_pool(pool_n);
      phase_end = words_sent + $urandom_range(150, 250);
      while (words_sent < phase_end && words_sent < WORDS_TOTAL) begin
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          send_word(random_access(pool_n), 1'b0, RES_NONE);
          if ($urandom_range(9) == 0) begin
            idle_gap($urandom_range(1, 5));
          end
        end
        if ($urandom_range(3) != 0) begin
          idle_gap($urandom_range(1, 300));
        end
      end
      drain_results();
      phase++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
